[rtl/skid_steer_wheel_odometry_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the skid-steer wheel odometry block
// Concurrent checks on clk, disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SKID_STEER_WHEEL_ODOMETRY_MACROS_SVH
`define SKID_STEER_WHEEL_ODOMETRY_MACROS_SVH
`ifndef SYNTHESIS
`define SSWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSWO_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define SSWO_ASSERT(lbl, prop, msg)
`define SSWO_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

[rtl/sswo_pkg.sv]
// ----------------------------------------------------------------------------
// Skid-steer wheel odometry package
// Widths, constants and the CORDIC arctangent table shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none
package sswo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int WIDE_W       = 72;
  localparam int MB_W         = 34;
  localparam int CW           = 34;
  localparam int DIV_CNT_W    = $clog2(WIDE_W + 1);

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [23:0]          TW_RESET    = 24'd28508;
  localparam logic                 REG_TRACK_WIDTH = 1'b0;

  localparam logic [WIDE_W-1:0] INV_PI_Q29 = WIDE_W'(64'd170891319);
  localparam logic [WIDE_W-1:0] ANG_SCALE  = WIDE_W'(64'd32768000000);
  localparam logic [MB_W-1:0]   LIN_SCALE  = MB_W'(250000);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_PREP = 14'b00000000000010,
    S_MDH  = 14'b00000000000100,
    S_DDH  = 14'b00000000001000,
    S_CMID = 14'b00000000010000,
    S_MX   = 14'b00000000100000,
    S_MY   = 14'b00000001000000,
    S_CQ   = 14'b00000010000000,
    S_MLN  = 14'b00000100000000,
    S_DLN  = 14'b00001000000000,
    S_MTD  = 14'b00010000000000,
    S_MAN  = 14'b00100000000000,
    S_DAN  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/skid_steer_wheel_odometry.sv]
// ----------------------------------------------------------------------------
// Skid-steer wheel odometry
// The first item after reset is only stored and gives no result.
// Later items pass through the bit-serial restoring divider (one to three
// divisions), the shift-add multiplier (one bit of the second operand a cycle,
// up to six products) and two 24-step CORDIC passes; one item at a time, the
// next request is taken once the result loads.
// Reset (synchronous): pose, heading and history cleared, track width 28508.
// ----------------------------------------------------------------------------
`default_nettype none
`include "skid_steer_wheel_odometry_macros.svh"
module skid_steer_wheel_odometry import sswo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // front_left_pos, front_right_pos, rear_left_pos, rear_right_pos,
  // sample_stamp_us, arrival_time_us
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pose_x, pose_y, quat_w, quat_z, linear_velocity, angular_velocity
  output logic [223:0] m_tdata,
  // time_fault
  output logic [0:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  state_t state, state_next;

  logic [23:0]        track_width;
  logic [23:0]        tw_eff;
  logic               have_prev;
  logic [31:0]        prev_pos [4];
  logic [47:0]        prev_stamp;
  logic [47:0]        pos_x;
  logic [47:0]        pos_y;
  logic [31:0]        heading;

  logic signed [33:0] s4;
  logic signed [34:0] d2;
  logic [48:0]        dt;
  logic [31:0]        dh;
  logic signed [31:0] cm;
  logic signed [31:0] sm;
  logic signed [31:0] qw;
  logic signed [31:0] qz;
  logic [31:0]        lin;
  logic [31:0]        ang;
  logic               fault;
  logic [WIDE_W-1:0]  den_r;

  logic [47:0]        o_x, o_y;
  logic [31:0]        o_w, o_z, o_lin, o_ang;
  logic               o_fault;

  logic               accept;
  logic               out_load;
  logic [31:0]        now_pos [4];
  logic [31:0]        dpos [4];
  logic signed [32:0] l2, r2;
  logic [33:0]        s4_mag, d2_mag;
  logic [34:0]        d2_neg;
  logic               dt_nonpos;
  logic [31:0]        dh_n;
  logic [32:0]        dx_r, dy_r;
  logic [63:0]        rnd_sum;
  logic               cfg_wr;

  logic               mul_start, mul_done;
  logic [WIDE_W-1:0]  mul_a, mul_prod;
  logic [MB_W-1:0]    mul_b;
  logic               div_start, div_done, div_big;
  logic [WIDE_W-1:0]  div_num, div_den;
  logic [31:0]        div_quo;
  logic               cor_start, cor_done;
  logic [31:0]        cor_phase;
  logic signed [31:0] cor_cos, cor_sin;

  function automatic logic [31:0] sat32(input logic neg, input logic big,
                                        input logic [31:0] q);
    logic [31:0] v;
    if (neg) begin
      v = (big || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
    end else begin
      v = (big || q[31]) ? 32'h7fff_ffff : q;
    end
    return v;
  endfunction

  function automatic logic [33:0] mag32(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? -v : v;
    return {2'b00, m};
  endfunction

  sswo_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a_in (mul_a),
    .b_in (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  sswo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .big  (div_big)
  );

  sswo_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cor_start),
    .phase(cor_phase),
    .done (cor_done),
    .cos_q(cor_cos),
    .sin_q(cor_sin)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && paddr[2] == REG_TRACK_WIDTH;
  assign prdata   = (paddr[2] == REG_TRACK_WIDTH) ? {8'b0, track_width} : 32'b0;
  assign tw_eff   = (track_width == '0) ? 24'd1 : track_width;

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_load = state == S_DONE && (!m_tvalid || m_tready);

  assign now_pos[0] = s_tdata[31:0];
  assign now_pos[1] = s_tdata[63:32];
  assign now_pos[2] = s_tdata[95:64];
  assign now_pos[3] = s_tdata[127:96];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dpos[k] = now_pos[k] - prev_pos[k];
    end
  end

  assign l2 = $signed({dpos[0][31], dpos[0]}) + $signed({dpos[2][31], dpos[2]});
  assign r2 = $signed({dpos[1][31], dpos[1]}) + $signed({dpos[3][31], dpos[3]});

  assign s4_mag    = s4[33] ? 34'(-s4) : 34'(s4);
  assign d2_neg    = -d2;
  assign d2_mag    = d2[34] ? d2_neg[33:0] : d2[33:0];
  assign dt_nonpos = dt[48] || dt == '0;
  assign dh_n      = d2[34] ? -div_quo : div_quo;
  assign rnd_sum   = mul_prod[63:0] + 64'h8000_0000;
  assign dx_r      = (s4[33] ^ cm[31]) ? -{1'b0, rnd_sum[63:32]} : {1'b0, rnd_sum[63:32]};
  assign dy_r      = (s4[33] ^ sm[31]) ? -{1'b0, rnd_sum[63:32]} : {1'b0, rnd_sum[63:32]};

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    cor_start  = 1'b0;
    cor_phase  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && have_prev) state_next = S_PREP;
      end
      S_PREP: begin
        mul_start  = 1'b1;
        mul_a      = INV_PI_Q29;
        mul_b      = d2_mag;
        state_next = S_MDH;
      end
      S_MDH: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_num    = mul_prod + WIDE_W'(tw_eff >> 1);
          div_den    = WIDE_W'(tw_eff);
          state_next = S_DDH;
        end
      end
      S_DDH: begin
        if (div_done) begin
          cor_start  = 1'b1;
          cor_phase  = {heading[30:0], 1'b0} + dh_n;
          state_next = S_CMID;
        end
      end
      S_CMID: begin
        if (cor_done) begin
          mul_start  = 1'b1;
          mul_a      = WIDE_W'(s4_mag);
          mul_b      = mag32(cor_cos);
          state_next = S_MX;
        end
      end
      S_MX: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = WIDE_W'(s4_mag);
          mul_b      = mag32(sm);
          state_next = S_MY;
        end
      end
      S_MY: begin
        if (mul_done) begin
          cor_start  = 1'b1;
          cor_phase  = heading + dh;
          state_next = S_CQ;
        end
      end
      S_CQ: begin
        if (cor_done) begin
          if (dt_nonpos) begin
            state_next = S_DONE;
          end else begin
            mul_start  = 1'b1;
            mul_a      = WIDE_W'(s4_mag);
            mul_b      = LIN_SCALE;
            state_next = S_MLN;
          end
        end
      end
      S_MLN: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_num    = mul_prod + WIDE_W'(dt[47:1]);
          div_den    = WIDE_W'(dt[47:0]);
          state_next = S_DLN;
        end
      end
      S_DLN: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = WIDE_W'(dt[47:0]);
          mul_b      = MB_W'(tw_eff);
          state_next = S_MTD;
        end
      end
      S_MTD: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = ANG_SCALE;
          mul_b      = d2_mag;
          state_next = S_MAN;
        end
      end
      S_MAN: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_num    = mul_prod + (den_r >> 1);
          div_den    = den_r;
          state_next = S_DAN;
        end
      end
      S_DAN: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      track_width <= TW_RESET;
      have_prev   <= 1'b0;
      prev_stamp  <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= '0;
      m_tvalid    <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        prev_pos[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr) track_width <= pwdata[23:0];
      if (accept) begin
        have_prev  <= 1'b1;
        prev_stamp <= s_tdata[175:128];
        for (int k = 0; k < 4; k++) begin
          prev_pos[k] <= now_pos[k];
        end
      end
      if (state == S_MX && mul_done) pos_x <= pos_x + {{15{dx_r[32]}}, dx_r};
      if (state == S_MY && mul_done) begin
        pos_y   <= pos_y + {{15{dy_r[32]}}, dy_r};
        heading <= heading + dh;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s4 <= 34'(l2) + 34'(r2);
      d2 <= 35'(r2) - 35'(l2);
      dt <= {1'b0, s_tdata[223:176]} - {1'b0, prev_stamp};
    end
    if (state == S_DDH && div_done) dh <= dh_n;
    if (state == S_CMID && cor_done) begin
      cm <= cor_cos;
      sm <= cor_sin;
    end
    if (state == S_CQ && cor_done) begin
      qw    <= cor_cos;
      qz    <= cor_sin;
      fault <= dt_nonpos;
      lin   <= '0;
      ang   <= '0;
    end
    if (state == S_DLN && div_done) lin <= sat32(s4[33], div_big, div_quo);
    if (state == S_MTD && mul_done) den_r <= mul_prod;
    if (state == S_DAN && div_done) ang <= sat32(d2[34], div_big, div_quo);
    if (out_load) begin
      o_x     <= pos_x;
      o_y     <= pos_y;
      o_w     <= qw;
      o_z     <= qz;
      o_lin   <= lin;
      o_ang   <= ang;
      o_fault <= fault;
    end
  end

  assign m_tdata = {o_ang, o_lin, o_z, o_w, o_y, o_x};
  assign m_tuser = o_fault;

  `SSWO_ASSERT(a_mul_done_state,
               mul_done |-> (state == S_MDH || state == S_MX || state == S_MY ||
                             state == S_MLN || state == S_MTD || state == S_MAN),
               "multiplier finished outside a multiply step")
  `SSWO_ASSERT(a_div_done_state,
               div_done |-> (state == S_DDH || state == S_DLN || state == S_DAN),
               "divider finished outside a divide step")
  `SSWO_ASSERT(a_cor_done_state, cor_done |-> (state == S_CMID || state == S_CQ),
               "rotation finished outside a rotation step")
  `SSWO_ASSERT(a_out_from_done, $rose(m_tvalid) |-> $past(state == S_DONE),
               "result raised without a finished item")
  `SSWO_ASSERT_NEXT(a_prep_starts, state == S_PREP, state == S_MDH,
                    "prepare step did not start the heading product")

endmodule
`default_nettype wire

[rtl/sswo_mul.sv]
// ----------------------------------------------------------------------------
// Shift-add multiplier
// One multiplier bit per cycle; finishes when the remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none
module sswo_mul import sswo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] a_in,
  input  logic [MB_W-1:0]   b_in,
  output logic              done,
  output logic [WIDE_W-1:0] prod
);

  logic              busy;
  logic [WIDE_W-1:0] a;
  logic [MB_W-1:0]   b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= a_in;
      b    <= b_in;
      prod <= '0;
    end else if (busy && b != '0) begin
      if (b[0]) begin
        prod <= prod + a;
      end
      a <= a << 1;
      b <= b >> 1;
    end
  end

endmodule
`default_nettype wire

[rtl/sswo_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; keeps the low 32 quotient bits and an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none
module sswo_div import sswo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] num,
  input  logic [WIDE_W-1:0] den,
  output logic              done,
  output logic [31:0]       quo,
  output logic              big
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WIDE_W-1:0]    n;
  logic [WIDE_W-1:0]    d;
  logic [WIDE_W-1:0]    r;
  logic [WIDE_W:0]      rs;
  logic [WIDE_W:0]      rdiff;
  logic                 fits;

  assign rs    = {r, n[WIDE_W-1]};
  assign fits  = rs >= {1'b0, d};
  assign rdiff = rs - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(WIDE_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      d   <= den;
      r   <= '0;
      quo <= '0;
      big <= 1'b0;
    end else if (busy) begin
      r   <= fits ? rdiff[WIDE_W-1:0] : rs[WIDE_W-1:0];
      n   <= n << 1;
      quo <= {quo[30:0], fits};
      big <= big | quo[31];
    end
  end

endmodule
`default_nettype wire

[rtl/sswo_cordic.sv]
// ----------------------------------------------------------------------------
// Rotation CORDIC
// One micro-rotation per cycle; cosine and sine, in Q2.30, of a 32-bit phase.
// ----------------------------------------------------------------------------
`default_nettype none
module sswo_cordic import sswo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic                 flip;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] ang;
  logic [31:0]          p_sum;
  logic [31:0]          p_fold;
  logic                 p_flip;

  function automatic logic signed [31:0] clamp(input logic signed [CW-1:0] v);
    logic signed [31:0] o;
    if (v > CW'(1073741824)) begin
      o = 32'sd1073741824;
    end else if (v < -CW'(1073741824)) begin
      o = -32'sd1073741824;
    end else begin
      o = 32'(v);
    end
    return o;
  endfunction

  assign p_sum  = phase + 32'h4000_0000;
  assign p_flip = p_sum[31];
  assign p_fold = p_flip ? phase ^ 32'h8000_0000 : phase;

  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign ang = $signed({2'b00, atan_entry(5'(step))});

  assign cos_q = clamp(flip ? -x : x);
  assign sin_q = clamp(flip ? -y : y);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({{(CW-32){p_fold[31]}}, p_fold});
      flip <= p_flip;
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
    end
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Skid-steer wheel odometry testbench
// Sends wheel readings and time stamps over the input stream and predicts the
// pose, the yaw quaternion and the velocities for each item after the first.
// Each result on the output stream is compared field by field with the oldest
// prediction. Runs directed cases, several track widths, a long output stall
// and random motion with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import sswo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_TRACK_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_UNUSED      = 3'd4;
  localparam int         DRAIN_CYCLES     = 600;

  typedef struct packed {
    logic [47:0] arrival;
    logic [47:0] stamp;
    logic [31:0] rr;
    logic [31:0] rl;
    logic [31:0] fr;
    logic [31:0] fl;
  } wheel_sample_t;

  typedef struct packed {
    logic        fault;
    logic [31:0] ang_vel;
    logic [31:0] lin_vel;
    logic [31:0] qz;
    logic [31:0] qw;
    logic [47:0] py;
    logic [47:0] px;
  } odom_pose_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [223:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  skid_steer_wheel_odometry DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

  // predictor state
  logic [23:0]        tw_reg;
  logic               have_prev;
  logic [31:0]        prev_pos [4];
  logic [47:0]        prev_stamp;
  logic [47:0]        pos_x, pos_y;
  logic [31:0]        hdg;
  odom_pose_t         pose_q [$];

  int  mismatches = 0;
  bit  gaps_on = 1'b1;
  int  hold_cycles = 0;
  int  stall_left = 0;

  logic [31:0] atan_lut [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  function automatic logic [127:0] div_nearest(input logic [127:0] n, input logic [127:0] d);
    return (n + (d >> 1)) / d;
  endfunction

  function automatic logic [31:0] sat_q16(input bit neg, input logic [127:0] q);
    if (neg) return (q > 128'h80000000) ? 32'h80000000 : 32'(-q);
    return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(q);
  endfunction

  function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] mul_round32(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic [127:0] m;
    logic [63:0]  r;
    bit           neg;
    neg = (a < 0) != (b < 0);
    m = 128'(abs64(a)) * 128'(abs64(b));
    r = 64'((m + 128'h80000000) >> 32);
    return neg ? -$signed(r) : $signed(r);
  endfunction

  task automatic rotate(input logic [31:0] phase, output logic signed [63:0] c,
                        output logic signed [63:0] s);
    logic [31:0] p;
    logic signed [63:0] x, y, z, xs, ys;
    bit flip;
    p = phase + 32'h40000000;
    flip = p[31];
    p = flip ? phase - 32'h80000000 : phase;
    x = 64'sd652032874;
    y = 0;
    z = 64'($signed(p));
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - 64'(atan_lut[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + 64'(atan_lut[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    if (x < -64'sd1073741824) x = -64'sd1073741824;
    if (y > 64'sd1073741824) y = 64'sd1073741824;
    if (y < -64'sd1073741824) y = -64'sd1073741824;
    c = x;
    s = y;
  endtask

  task automatic predict_odometry(input wheel_sample_t w);
    logic [31:0] now [4];
    logic signed [63:0] d [4];
    logic signed [63:0] l2, r2, s4, d2, dh, c, s, dt;
    logic [127:0] q, tw;
    logic [31:0] ph;
    odom_pose_t r;
    now[0] = w.fl; now[1] = w.fr; now[2] = w.rl; now[3] = w.rr;
    tw = (tw_reg == 0) ? 128'd1 : 128'(tw_reg);
    if (!have_prev) begin
      for (int k = 0; k < 4; k++) prev_pos[k] = now[k];
      prev_stamp = w.stamp;
      have_prev = 1'b1;
      return;
    end
    for (int k = 0; k < 4; k++) begin
      d[k] = 64'($signed(now[k] - prev_pos[k]));
      prev_pos[k] = now[k];
    end
    l2 = d[0] + d[2];
    r2 = d[1] + d[3];
    s4 = l2 + r2;
    d2 = r2 - l2;
    q = div_nearest(128'(abs64(d2)) * 128'd170891319, tw);
    dh = d2 < 0 ? -$signed(64'(q)) : $signed(64'(q));
    ph = (hdg << 1) + dh[31:0];
    rotate(ph, c, s);
    pos_x = pos_x + 48'(mul_round32(s4, c));
    pos_y = pos_y + 48'(mul_round32(s4, s));
    hdg = hdg + dh[31:0];
    rotate(hdg, c, s);
    dt = $signed({16'd0, w.arrival}) - $signed({16'd0, prev_stamp});
    prev_stamp = w.stamp;
    r.px = pos_x;
    r.py = pos_y;
    r.qw = c[31:0];
    r.qz = s[31:0];
    if (dt <= 0) begin
      r.lin_vel = '0; r.ang_vel = '0; r.fault = 1'b1;
    end else begin
      q = div_nearest(128'(abs64(s4)) * 128'd250000, 128'(dt));
      r.lin_vel = sat_q16(s4 < 0, q);
      q = div_nearest(128'(abs64(d2)) * 128'd32768000000, tw * 128'(dt));
      r.ang_vel = sat_q16(d2 < 0, q);
      r.fault = 1'b0;
    end
    pose_q.push_back(r);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_TRACK_WIDTH) tw_reg = data[23:0];
  endtask

  task automatic send_sample(input wheel_sample_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w.arrival, w.stamp, w.rr, w.rl, w.fr, w.fl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_odometry(w);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // motion generator
  logic [31:0] cur_pos [4];
  logic [47:0] cur_time = 48'd1000;

  task automatic move_step(input int step_max, input int pct_fault, input int pct_wild);
    wheel_sample_t w;
    logic [47:0] st;
    int base;
    base = $urandom_range(0, 2 * step_max) - step_max;
    for (int k = 0; k < 4; k++)
      cur_pos[k] = cur_pos[k] + 32'(base + int'($urandom_range(0, step_max / 4 + 1)));
    if ($urandom_range(0, 99) < pct_wild)
      for (int k = 0; k < 4; k++) cur_pos[k] = $urandom();
    cur_time = cur_time + 48'($urandom_range(1, 20000));
    st = cur_time - 48'($urandom_range(0, 300));
    w.fl = cur_pos[0]; w.fr = cur_pos[1]; w.rl = cur_pos[2]; w.rr = cur_pos[3];
    w.stamp = st;
    w.arrival = cur_time;
    if ($urandom_range(0, 99) < pct_fault)
      w.arrival = prev_stamp - 48'($urandom_range(0, 50));
    if ($urandom_range(0, 99) < pct_wild) begin
      w.stamp = {$urandom(), $urandom()};
      w.arrival = {$urandom(), $urandom()};
      cur_time = w.stamp;
    end
    send_sample(w);
  endtask

  task automatic send_fields(input logic [31:0] fl, fr, rl, rr, input logic [47:0] st, arr);
    wheel_sample_t w;
    w.fl = fl; w.fr = fr; w.rl = rl; w.rr = rr; w.stamp = st; w.arrival = arr;
    send_sample(w);
  endtask

  task automatic test_directed;
    send_fields(32'h0, 32'h0, 32'h0, 32'h0, 48'd0, 48'd0);
    send_fields(32'h0, 32'h0, 32'h0, 32'h0, 48'd100, 48'd100);
    send_fields(32'h10000, 32'h10000, 32'h10000, 32'h10000, 48'd200, 48'd1100);
    send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'd300, 48'd201);
    send_fields(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 48'd400, 48'd301);
    send_fields(32'h0, 32'h80000000, 32'h0, 32'h80000000, 48'd500, 48'd401);
    send_fields(32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h0, 48'd600, 48'd500);
    send_fields(32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h0, 48'd700, 48'd100);
    send_fields(32'h7FFF0000, 32'h80010000, 32'h7FFF0000, 32'h80010000, 48'd800, 48'd900);
    send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF);
    send_fields(32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001,
                48'd0, 48'hFFFFFFFFFFFF);
    send_fields(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                48'h555555555555, 48'hAAAAAAAAAAAA);
    send_fields(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                48'hAAAAAAAAAAAA, 48'hAAAAAAAAAAAA);
    for (int i = 0; i < 8; i++) move_step(30000, 10, 0);
    drain();
  endtask

  task automatic test_track_width;
    logic [31:0] widths [6] = '{32'd1, 32'd0, 32'h00FFFFFF, 32'hFFFFFFFF, 32'd65536,
                               32'd28508};
    reg_write(ADDR_UNUSED, $urandom());
    foreach (widths[i]) begin
      reg_write(ADDR_TRACK_WIDTH, widths[i]);
      for (int j = 0; j < 12; j++) move_step(i == 0 ? 3000 : 60000, 10, 5);
      drain();
    end
  endtask

  task automatic test_output_stall;
    hold_cycles = 4000;
    for (int i = 0; i < 20; i++) move_step(20000, 5, 0);
    drain();
  endtask

  task automatic test_random;
    for (int i = 0; i < 1250; i++) begin
      if (i % 150 == 0) gaps_on = $urandom_range(0, 2) != 0;
      if (i % 300 == 299) begin
        drain();
        reg_write(ADDR_TRACK_WIDTH, $urandom_range(1, 400000));
      end
      move_step($urandom_range(0, 3) == 0 ? 2000000 : 40000, 4, 3);
    end
    gaps_on = 1'b1;
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      stall_left = gaps_on ? $urandom_range(0, 13) : 0;
      m_tready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= (stall_left == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    odom_pose_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[223:192], m_tdata[191:160], m_tdata[159:128],
             m_tdata[127:96], m_tdata[95:48], m_tdata[47:0]};
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pose_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch x %h/%h y %h/%h w %h/%h z %h/%h lin %h/%h ang %h/%h f %b/%b",
                     want.px, got.px, want.py, got.py, want.qw, got.qw, want.qz, got.qz,
                     want.lin_vel, got.lin_vel, want.ang_vel, got.ang_vel,
                     want.fault, got.fault);
        end
      end
    end
  end

  initial begin
    tw_reg = TW_RESET;
    have_prev = 1'b0;
    foreach (prev_pos[k]) prev_pos[k] = '0;
    foreach (cur_pos[k]) cur_pos[k] = $urandom();
    prev_stamp = '0;
    pos_x = '0;
    pos_y = '0;
    hdg = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_track_width();
    test_output_stall();
    test_random();
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
